>>> rtl/lidar_sector_wall_follow_steering_defines.svh
// assertion macros for the lidar sector wall-follow steering block
// used by the top level; expects clk_i and rst_ni in scope
`ifndef LIDAR_SECTOR_WALL_FOLLOW_STEERING_DEFINES_SVH
`define LIDAR_SECTOR_WALL_FOLLOW_STEERING_DEFINES_SVH

// checked only out of reset
`define LSWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define LSWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lsws_pkg.sv
// types, constants and register codes of the lidar sector wall-follow steering block
// no dependencies; used by the interfaces and every module
package lsws_pkg;

  localparam int SECTORS    = 8;
  localparam int SEC_W      = $clog2(SECTORS);
  localparam int MAX_POINTS = 4096;
  localparam int MIN_POINTS = 16;
  localparam int RANGE_W    = 16;
  localparam int IDX_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SPEED_W    = 5;
  localparam int TURN_W     = 4;

  typedef logic [RANGE_W-1:0]       range_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [SEC_W-1:0]         sec_t;
  typedef logic [SPEED_W-1:0]       speed_t;
  typedef logic signed [TURN_W-1:0] turn_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

  localparam idx_t INDEX_TOP = {IDX_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE  = 3'd0,
    CFG_SCAN_POINTS = 3'd1,
    CFG_FRONT_CLEAR = 3'd2,
    CFG_WALL_NEAR   = 3'd3,
    CFG_WALL_FAR    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ACT_STOPPED     = 3'd0,
    ACT_NO_SCAN     = 3'd1,
    ACT_TURN_LEFT   = 3'd2,
    ACT_RIGHT_CORNER = 3'd3,
    ACT_STEER_LEFT  = 3'd4,
    ACT_STEER_RIGHT = 3'd5,
    ACT_STRAIGHT    = 3'd6
  } action_e;

  localparam idx_t   RST_SCAN_POINTS = IDX_W'(360);
  localparam range_t RST_FRONT_CLEAR = RANGE_W'(300);
  localparam range_t RST_WALL_NEAR   = RANGE_W'(200);
  localparam range_t RST_WALL_FAR    = RANGE_W'(300);

  localparam speed_t SPEED_STOP = SPEED_W'(0);
  localparam speed_t SPEED_SLOW = SPEED_W'(10);
  localparam speed_t SPEED_FULL = SPEED_W'(20);
  localparam turn_t  TURN_NONE  = TURN_W'(0);
  localparam turn_t  TURN_HARD_LEFT = TURN_W'(5);
  localparam turn_t  TURN_LEFT  = TURN_W'(3);
  localparam turn_t  TURN_RIGHT = -TURN_W'(3);

  typedef struct packed {
    logic hit;
    sec_t idx;
  } sect_t;

  typedef struct packed {
    action_e action;
    speed_t  speed;
    turn_t   turn;
  } cmd_t;

endpackage

>>> rtl/lsws_if.sv
// channel interfaces: sample/tick input, steering command output, register writes
// depends on lsws_pkg
interface lsws_in_if;
  import lsws_pkg::*;
  logic   valid;
  logic   ready;
  logic   kind;
  range_t range_mm;
  logic   last;
  modport source (output valid, kind, range_mm, last, input ready);
  modport sink   (input valid, kind, range_mm, last, output ready);
endinterface

interface lsws_out_if;
  import lsws_pkg::*;
  logic    valid;
  logic    ready;
  action_e action;
  speed_t  linear_speed;
  turn_t   turn_rate;
  modport source (output valid, action, linear_speed, turn_rate, input ready);
  modport sink   (input valid, action, linear_speed, turn_rate, output ready);
endinterface

interface lsws_cfg_if;
  import lsws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  cfg_data_t            data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/lsws_sector_map.sv
// maps a sample index to its angular window for the current scan length
// depends on lsws_pkg
module lsws_sector_map (
  input  lsws_pkg::idx_t  sample_index_i,
  input  lsws_pkg::idx_t  scan_points_i,
  output lsws_pkg::sect_t sect_o
);
  import lsws_pkg::*;

  idx_t n;
  idx_t iv;
  idx_t h;
  idx_t lo [SECTORS];
  idx_t sel_lo;
  logic [SEC_W:0] m_sel;

  always_comb begin
    priority if (scan_points_i < IDX_W'(MIN_POINTS)) begin
      n = IDX_W'(MIN_POINTS);
    end else if (scan_points_i > IDX_W'(MAX_POINTS)) begin
      n = IDX_W'(MAX_POINTS);
    end else begin
      n = scan_points_i;
    end
    iv = n >> SEC_W;
    h  = iv >> 1;

    // window k+1 opens at (k+1)*iv - h; keep the last one already passed
    m_sel  = '0;
    sel_lo = '0;
    for (int k = 0; k < SECTORS; k++) begin
      lo[k] = IDX_W'(k + 1) * iv - h;
      if (sample_index_i >= lo[k]) begin
        m_sel  = (SEC_W+1)'(k + 1);
        sel_lo = lo[k];
      end
    end

    sect_o = '{hit: 1'b0, idx: '0};
    priority if (sample_index_i >= n) begin
      sect_o.hit = 1'b0;
    end else if (sample_index_i >= n - h || sample_index_i < h) begin
      // wrap window around index zero
      sect_o.hit = 1'b1;
    end else if (m_sel == '0 || m_sel == (SEC_W+1)'(SECTORS)) begin
      sect_o.hit = 1'b0;
    end else begin
      sect_o.hit = sample_index_i < sel_lo + (h << 1);
      sect_o.idx = m_sel[SEC_W-1:0];
    end
  end

endmodule

>>> rtl/lsws_rules.sv
// wall-follow rules: latched sector minima and thresholds to one steering command
// depends on lsws_pkg
module lsws_rules (
  input  logic             run_enable_i,
  input  logic             scan_valid_i,
  input  lsws_pkg::range_t front_clear_i,
  input  lsws_pkg::range_t wall_near_i,
  input  lsws_pkg::range_t wall_far_i,
  input  lsws_pkg::range_t minima_i [lsws_pkg::SECTORS],
  output lsws_pkg::cmd_t   cmd_o
);
  import lsws_pkg::*;

  localparam int W2 = RANGE_W + 2;
  localparam int W4 = RANGE_W + 4;

  logic front_block;
  logic corner;
  logic drift_left;
  logic drift_right;

  always_comb begin
    front_block = minima_i[0] < front_clear_i || minima_i[1] < front_clear_i ||
                  minima_i[0] < minima_i[6] || minima_i[1] < minima_i[6] ||
                  minima_i[2] < minima_i[6];
    // 2*r7 > 3*r6
    corner = (W2'(minima_i[7]) << 1) > (W2'(minima_i[6]) << 1) + W2'(minima_i[6]);
    // 10*r7 < 9*r5 and its mirror, done with shifts
    drift_left  = (W4'(minima_i[7]) << 3) + (W4'(minima_i[7]) << 1) <
                  (W4'(minima_i[5]) << 3) + W4'(minima_i[5]) ||
                  minima_i[6] < wall_near_i;
    drift_right = (W4'(minima_i[5]) << 3) + (W4'(minima_i[5]) << 1) <
                  (W4'(minima_i[7]) << 3) + W4'(minima_i[7]) ||
                  minima_i[6] > wall_far_i;

    priority if (!run_enable_i) begin
      cmd_o = '{action: ACT_STOPPED, speed: SPEED_STOP, turn: TURN_NONE};
    end else if (!scan_valid_i) begin
      cmd_o = '{action: ACT_NO_SCAN, speed: SPEED_STOP, turn: TURN_NONE};
    end else if (front_block) begin
      cmd_o = '{action: ACT_TURN_LEFT, speed: SPEED_STOP, turn: TURN_HARD_LEFT};
    end else if (corner) begin
      cmd_o = '{action: ACT_RIGHT_CORNER, speed: SPEED_SLOW, turn: TURN_RIGHT};
    end else if (drift_left) begin
      cmd_o = '{action: ACT_STEER_LEFT, speed: SPEED_SLOW, turn: TURN_LEFT};
    end else if (drift_right) begin
      cmd_o = '{action: ACT_STEER_RIGHT, speed: SPEED_SLOW, turn: TURN_RIGHT};
    end else begin
      cmd_o = '{action: ACT_STRAIGHT, speed: SPEED_FULL, turn: TURN_NONE};
    end
  end

endmodule

>>> rtl/lidar_sector_wall_follow_steering.sv
// top level: input stage, sector minima, scan latch, command output register
// depends on lsws_pkg, lsws_if, lsws_sector_map, lsws_rules and the defines header
//
//   channel | dir | word                             | accepted when
//   in_ch   | in  | kind, range_mm, last             | valid && ready
//   out_ch  | out | action, linear_speed, turn_rate  | valid && ready
//   cfg_ch  | in  | index, data                      | valid && ready (ready always high)
//
// one word per cycle while the input is not stalled; a word passes through the input
// register, and a tick's command is loaded from it into the output register
// a sample in the input register never waits; a tick waits only while the output
// register holds a word that is not being taken, and the input stalls behind it
// reset clears control state and sector minima and sets the configuration registers to their reset values
`include "lidar_sector_wall_follow_steering_defines.svh"

module lidar_sector_wall_follow_steering (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsws_in_if.sink    in_ch,
  lsws_out_if.source out_ch,
  lsws_cfg_if.sink   cfg_ch
);
  import lsws_pkg::*;

  // configuration
  logic   run_enable_q;
  idx_t   scan_points_q;
  range_t front_clear_q;
  range_t wall_near_q;
  range_t wall_far_q;

  // input stage
  logic   s1_valid_q, s1_valid_d;
  logic   s1_kind_q;
  range_t s1_range_q;
  logic   s1_last_q;
  logic   s1_go;
  logic   in_acc;

  // scan state
  idx_t   sample_index_q, sample_index_d;
  range_t wmin_q [SECTORS];
  range_t wmin_d [SECTORS];
  range_t lat_q [SECTORS];
  range_t lat_d [SECTORS];
  logic   scan_valid_q, scan_valid_d;

  // output stage
  logic   out_valid_q, out_valid_d;
  cmd_t   out_q;
  cmd_t   cmd;
  sect_t  sect;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_enable_q  <= 1'b0;
      scan_points_q <= RST_SCAN_POINTS;
      front_clear_q <= RST_FRONT_CLEAR;
      wall_near_q   <= RST_WALL_NEAR;
      wall_far_q    <= RST_WALL_FAR;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_RUN_ENABLE:  run_enable_q  <= cfg_ch.data[0];
        CFG_SCAN_POINTS: scan_points_q <= cfg_ch.data[IDX_W-1:0];
        CFG_FRONT_CLEAR: front_clear_q <= cfg_ch.data[RANGE_W-1:0];
        CFG_WALL_NEAR:   wall_near_q   <= cfg_ch.data[RANGE_W-1:0];
        CFG_WALL_FAR:    wall_far_q    <= cfg_ch.data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // a sample always completes; a tick needs room in the output register
  assign s1_go       = s1_valid_q && (!s1_kind_q || !out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    priority if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= in_ch.kind;
      s1_range_q <= in_ch.range_mm;
      s1_last_q  <= in_ch.last;
    end
  end

  lsws_sector_map u_sector_map (
    .sample_index_i (sample_index_q),
    .scan_points_i  (scan_points_q),
    .sect_o         (sect)
  );

  // a zero minimum doubles as "sector not seen yet"
  always_comb begin
    sample_index_d = sample_index_q;
    scan_valid_d   = scan_valid_q;
    wmin_d         = wmin_q;
    lat_d          = lat_q;
    if (s1_go && !s1_kind_q) begin
      if (sect.hit && s1_range_q != '0 &&
          (wmin_q[sect.idx] == '0 || s1_range_q < wmin_q[sect.idx])) begin
        wmin_d[sect.idx] = s1_range_q;
      end
      if (sample_index_q != INDEX_TOP) begin
        sample_index_d = sample_index_q + IDX_W'(1);
      end
      if (s1_last_q) begin
        lat_d          = wmin_d;
        sample_index_d = '0;
        scan_valid_d   = 1'b1;
        for (int k = 0; k < SECTORS; k++) begin
          wmin_d[k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      scan_valid_q   <= 1'b0;
      for (int k = 0; k < SECTORS; k++) begin
        wmin_q[k] <= '0;
        lat_q[k]  <= '0;
      end
    end else begin
      sample_index_q <= sample_index_d;
      scan_valid_q   <= scan_valid_d;
      wmin_q         <= wmin_d;
      lat_q          <= lat_d;
    end
  end

  lsws_rules u_rules (
    .run_enable_i  (run_enable_q),
    .scan_valid_i  (scan_valid_q),
    .front_clear_i (front_clear_q),
    .wall_near_i   (wall_near_q),
    .wall_far_i    (wall_far_q),
    .minima_i      (lat_q),
    .cmd_o         (cmd)
  );

  always_comb begin
    priority if (s1_go && s1_kind_q) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_kind_q) begin
      out_q <= cmd;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.action       = out_q.action;
  assign out_ch.linear_speed = out_q.speed;
  assign out_ch.turn_rate    = out_q.turn;

  `LSWS_ASSERT(a_word_only_from_tick, $rose(out_valid_q) |-> $past(s1_go && s1_kind_q), "command word without a tick")
  `LSWS_ASSERT(a_last_closes_scan, (s1_go && !s1_kind_q && s1_last_q) |=> (scan_valid_q && sample_index_q == '0), "scan end did not latch")
  `LSWS_ASSERT(a_stall_only_on_tick, !in_ch.ready |-> (s1_valid_q && s1_kind_q && out_valid_q && !out_ch.ready), "input stalled without a blocked tick")
  `LSWS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_q && !s1_valid_q), "valid during reset")

endmodule

>>> dv/testbench.sv
// testbench for the lidar sector wall-follow steering block: drives samples, ticks and
// register writes with random gaps, predicts every steering command and checks it
// depends on lsws_pkg, lsws_if and the top level lidar_sector_wall_follow_steering
`timescale 1ns / 1ps

module testbench;
  import lsws_pkg::*;

  localparam longint TIMEOUT_NS   = 64'd40_000_000;
  localparam int     SETTLE_CYC   = 8;
  localparam int     LONG_HOLD    = 400;
  localparam int     RANDOM_WORDS = 1300;

  typedef struct {
    logic   kind;
    range_t range_mm;
    logic   last;
  } sample_word_t;

  logic clk_i;
  logic rst_ni;

  lsws_in_if  in_bus ();
  lsws_out_if out_bus ();
  lsws_cfg_if cfg_bus ();

  lidar_sector_wall_follow_steering i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source),
    .cfg_ch (cfg_bus.sink)
  );

  // words waiting for the driver, commands waiting for the output
  sample_word_t word_queue[$];
  cmd_t         cmd_expected[$];
  int unsigned  words_sent;
  int unsigned  words_taken;
  int           mismatches;

  // gap control
  bit          in_idle_on;
  bit          out_idle_on;
  bit          hold_request;
  int unsigned in_gap_left;
  int unsigned hold_left;

  // predictor copy of registers and state
  bit          run_en;
  int unsigned scan_len;
  int unsigned front_clear;
  int unsigned wall_near;
  int unsigned wall_far;
  int unsigned sample_idx;
  int unsigned work_min [SECTORS];
  bit          seen     [SECTORS];
  int unsigned held_min [SECTORS];
  bit          scan_held;

  // register values as the stimulus sees them
  int unsigned stim_points;
  int unsigned stim_front;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned points_eff(int unsigned n);
    if (n < MIN_POINTS) return MIN_POINTS;
    if (n > MAX_POINTS) return MAX_POINTS;
    return n;
  endfunction

  // window of sample i, -1 where it falls in no window
  function automatic int sector_for(int unsigned i, int unsigned n_raw);
    int unsigned n;
    int unsigned iv;
    int unsigned h;
    int unsigned j;
    int unsigned m;
    n  = points_eff(n_raw);
    iv = n / SECTORS;
    h  = iv / 2;
    if (i >= n) return -1;
    if (i >= n - h) return 0;
    j = i + h;
    m = j / iv;
    if (m >= SECTORS || j - m * iv >= 2 * h) return -1;
    return int'(m);
  endfunction

  function automatic cmd_t steer_for_tick();
    cmd_t c;
    if (!run_en) begin
      c = '{ACT_STOPPED, SPEED_STOP, TURN_NONE};
    end else if (!scan_held) begin
      c = '{ACT_NO_SCAN, SPEED_STOP, TURN_NONE};
    end else if (held_min[0] < front_clear || held_min[1] < front_clear ||
                 held_min[0] < held_min[6] || held_min[1] < held_min[6] ||
                 held_min[2] < held_min[6]) begin
      c = '{ACT_TURN_LEFT, SPEED_STOP, TURN_HARD_LEFT};
    end else if (2 * held_min[7] > 3 * held_min[6]) begin
      c = '{ACT_RIGHT_CORNER, SPEED_SLOW, TURN_RIGHT};
    end else if (10 * held_min[7] < 9 * held_min[5] || held_min[6] < wall_near) begin
      c = '{ACT_STEER_LEFT, SPEED_SLOW, TURN_LEFT};
    end else if (10 * held_min[5] < 9 * held_min[7] || held_min[6] > wall_far) begin
      c = '{ACT_STEER_RIGHT, SPEED_SLOW, TURN_RIGHT};
    end else begin
      c = '{ACT_STRAIGHT, SPEED_FULL, TURN_NONE};
    end
    return c;
  endfunction

  task automatic absorb_word(input sample_word_t w);
    int          s;
    int unsigned rv;
    int          k;
    if (w.kind == 1'b0) begin
      rv = 32'(w.range_mm);
      s  = sector_for(sample_idx, scan_len);
      if (s >= 0 && rv != 0 && (!seen[s] || rv < work_min[s])) begin
        work_min[s] = rv;
        seen[s]     = 1'b1;
      end
      if (sample_idx < INDEX_TOP) sample_idx++;
      if (w.last) begin
        for (k = 0; k < SECTORS; k++) begin
          held_min[k] = seen[k] ? work_min[k] : 0;
          work_min[k] = 0;
          seen[k]     = 1'b0;
        end
        scan_held  = 1'b1;
        sample_idx = 0;
      end
    end else begin
      cmd_expected.push_back(steer_for_tick());
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_data_t d);
    case (cfg_reg_e'(idx))
      CFG_RUN_ENABLE:  run_en      = d[0];
      CFG_SCAN_POINTS: scan_len    = 32'(d[IDX_W-1:0]);
      CFG_FRONT_CLEAR: front_clear = 32'(d);
      CFG_WALL_NEAR:   wall_near   = 32'(d);
      CFG_WALL_FAR:    wall_far    = 32'(d);
      default: ;
    endcase
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // input driver
  always @(posedge clk_i) begin
    sample_word_t w;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !in_bus.ready)) begin
      if (in_bus.valid && in_idle_on) in_gap_left = idle_len();
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_bus.valid <= 1'b0;
      end else if (word_queue.size() != 0) begin
        w = word_queue.pop_front();
        in_bus.kind     <= w.kind;
        in_bus.range_mm <= w.range_mm;
        in_bus.last     <= w.last;
        in_bus.valid    <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // output ready, with random stalls and the long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 99) < 20) begin
      hold_left = idle_len();
      out_bus.ready <= (hold_left == 0);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // monitor: register writes, accepted words, returned commands
  always @(posedge clk_i) begin
    sample_word_t w;
    cmd_t         want;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) apply_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        w.kind     = in_bus.kind;
        w.range_mm = in_bus.range_mm;
        w.last     = in_bus.last;
        absorb_word(w);
        words_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (cmd_expected.size() == 0) begin
          $display("%0t: unexpected command: action %0d speed %0d turn %0d", $time,
                   out_bus.action, out_bus.linear_speed, out_bus.turn_rate);
          mismatches++;
        end else begin
          want = cmd_expected.pop_front();
          if (out_bus.action !== want.action || out_bus.linear_speed !== want.speed ||
              out_bus.turn_rate !== want.turn) begin
            $display("%0t: command mismatch: expected action %0d speed %0d turn %0d, got %s",
                     $time, want.action, want.speed, want.turn,
                     $sformatf("action %0d speed %0d turn %0d", out_bus.action,
                               out_bus.linear_speed, out_bus.turn_rate));
            mismatches++;
          end
        end
      end
    end
  end

  task automatic push_word(input logic kind, input range_t rng, input logic last);
    sample_word_t w;
    w.kind     = kind;
    w.range_mm = rng;
    w.last     = last;
    word_queue.push_back(w);
    words_sent++;
  endtask

  // wait until every word is taken and every command returned, then let the pipe drain
  task automatic settle();
    while (words_sent != words_taken || cmd_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(input cfg_reg_e r, input cfg_data_t d);
    @(posedge clk_i);
    cfg_bus.index <= r;
    cfg_bus.data  <= d;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic int unsigned pick_threshold(int unsigned nominal);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r == 2) return $urandom_range(0, 65535);
    return nominal - 50 + $urandom_range(0, 100);
  endfunction

  function automatic int unsigned clip16(int unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  // per-sector target minima, mostly shaped around the steering thresholds
  task automatic make_targets(output int unsigned tgt[SECTORS]);
    int unsigned mode;
    int unsigned r6;
    int unsigned r7;
    int          k;
    mode = $urandom_range(0, 9);
    for (k = 0; k < SECTORS; k++) tgt[k] = $urandom_range(1, 65535);
    if (mode == 0) begin
      for (k = 0; k < SECTORS; k++) if ($urandom_range(0, 7) == 0) tgt[k] = 0;
    end else if (mode == 1) begin
      tgt[$urandom_range(0, 2)] = $urandom_range(1, 400);
    end else begin
      r6 = $urandom_range(40, 800);
      for (k = 0; k < 3; k++)
        tgt[k] = clip16(((stim_front > r6) ? stim_front : r6) + $urandom_range(0, 3000));
      case ($urandom_range(0, 5))
        0: r7 = r6 * 3 / 2 + 1;
        1: begin
          r6 = r6 & ~32'd1;
          r7 = r6 * 3 / 2;
        end
        default: r7 = $urandom_range(r6 * 2 / 3, r6 * 3 / 2);
      endcase
      tgt[6] = r6;
      tgt[7] = r7;
      // exact ratio boundaries now and then
      case ($urandom_range(0, 4))
        0: tgt[5] = (r7 / 9) * 10;
        1: tgt[5] = (r7 / 10) * 9;
        default: tgt[5] = r7 * $urandom_range(80, 125) / 100;
      endcase
    end
  endtask

  task automatic send_scan(input int unsigned len, input bit with_last,
                           input int unsigned tgt[SECTORS]);
    int unsigned i;
    int unsigned v;
    int unsigned pick;
    int          s;
    for (i = 0; i < len; i++) begin
      s    = sector_for(i, stim_points);
      pick = $urandom_range(0, 7);
      if (s < 0) v = $urandom_range(0, 65535);
      else if (tgt[s] == 0 || pick == 0) v = 0;
      else if (pick < 5) v = tgt[s];
      else v = clip16(tgt[s] + $urandom_range(1, 500));
      push_word(1'b0, range_t'(v), with_last && (i == len - 1));
      if ($urandom_range(0, 99) < 3) push_word(1'b1, range_t'($urandom), 1'($urandom));
      // stray word that may cut the scan short
      if ($urandom_range(0, 99) < 2)
        push_word(1'($urandom), range_t'($urandom), ($urandom_range(0, 3) == 0));
    end
  endtask

  task automatic random_phase();
    int unsigned tgt[SECTORS];
    int unsigned n_eff;
    int unsigned len;
    int unsigned pick;
    int unsigned scans;
    bit          with_last;
    settle();
    case ($urandom_range(0, 19))
      0: stim_points = 0;
      1: stim_points = 8191;
      2: stim_points = 16;
      3: stim_points = MAX_POINTS;
      4: stim_points = 15;
      5: stim_points = 17;
      default: stim_points = $urandom_range(16, 100);
    endcase
    stim_front = pick_threshold(300);
    reg_write(CFG_RUN_ENABLE, {15'($urandom), ($urandom_range(0, 9) != 0)});
    reg_write(CFG_SCAN_POINTS, {3'($urandom), 13'(stim_points)});
    reg_write(CFG_FRONT_CLEAR, cfg_data_t'(stim_front));
    reg_write(CFG_WALL_NEAR, cfg_data_t'(pick_threshold(200)));
    reg_write(CFG_WALL_FAR, cfg_data_t'(pick_threshold(300)));
    in_idle_on  = ($urandom_range(0, 3) != 0);
    out_idle_on = ($urandom_range(0, 3) != 0);
    n_eff = points_eff(stim_points);
    scans = $urandom_range(2, 4);
    repeat (scans) begin
      make_targets(tgt);
      pick = $urandom_range(0, 99);
      // big scans stay short
      if (n_eff > 200) len = $urandom_range(20, 250);
      else if (pick < 70) len = n_eff;
      else if (pick < 85) len = $urandom_range(1, n_eff - 1);
      else len = n_eff + $urandom_range(1, 20);
      with_last = ($urandom_range(0, 9) != 0);
      send_scan(len, with_last, tgt);
      repeat ($urandom_range(1, 3)) push_word(1'b1, range_t'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int          i;
    int unsigned base;
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.kind     = 1'b0;
    in_bus.range_mm = '0;
    in_bus.last     = 1'b0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    in_idle_on      = 1'b1;
    out_idle_on     = 1'b1;
    hold_request    = 1'b0;
    in_gap_left     = 0;
    hold_left       = 0;
    words_sent      = 0;
    words_taken     = 0;
    mismatches      = 0;
    run_en          = 1'b0;
    scan_len        = 32'(RST_SCAN_POINTS);
    front_clear     = 32'(RST_FRONT_CLEAR);
    wall_near       = 32'(RST_WALL_NEAR);
    wall_far        = 32'(RST_WALL_FAR);
    sample_idx      = 0;
    scan_held       = 1'b0;
    for (i = 0; i < SECTORS; i++) begin
      work_min[i] = 0;
      seen[i]     = 1'b0;
      held_min[i] = 0;
    end
    stim_points = 32'(RST_SCAN_POINTS);
    stim_front  = 32'(RST_FRONT_CLEAR);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: stopped out of reset, no scan yet, extremes, empty sector, short scan
    push_word(1'b1, '0, 1'b0);
    settle();
    reg_write(CFG_RUN_ENABLE, 16'd1);
    reg_write(CFG_SCAN_POINTS, 16'd16);
    stim_points = 16;
    push_word(1'b1, 16'hFFFF, 1'b1);
    for (i = 0; i < 16; i++) begin
      case (i)
        0, 15:   push_word(1'b0, 16'hFFFF, i == 15);
        1, 2:    push_word(1'b0, 16'h0000, 1'b0);
        3:       push_word(1'b0, 16'h0001, 1'b0);
        default: push_word(1'b0, range_t'($urandom_range(1, 65535)), 1'b0);
      endcase
    end
    push_word(1'b1, '0, 1'b0);
    push_word(1'b0, 16'h8000, 1'b0);
    push_word(1'b0, 16'h7FFF, 1'b0);
    push_word(1'b0, 16'h0001, 1'b1);
    push_word(1'b1, '0, 1'b0);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) random_phase();

    // long output hold while ticks keep coming, so the input backs up
    settle();
    stim_points = 40;
    reg_write(CFG_SCAN_POINTS, 16'd40);
    in_idle_on   = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) push_word(1'b0, range_t'($urandom_range(1, 2000)), i == 39);
    for (i = 0; i < 30; i++) push_word(1'b1, range_t'($urandom), 1'($urandom));
    settle();
    random_phase();

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lsws_pkg.sv
rtl/lsws_if.sv
rtl/lsws_sector_map.sv
rtl/lsws_rules.sv
rtl/lidar_sector_wall_follow_steering.sv
dv/testbench.sv
